### hw/rtl/scpb_pkg.sv
// Shared types and constants for the cone pair bounds test.
package scpb_pkg;

    // Configuration register indexes, in port order.
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CONE_A_AXIS        = 3'd0,
        CFG_CONE_A_COS         = 3'd1,
        CFG_CONE_B_AXIS        = 3'd2,
        CFG_CONE_B_COS         = 3'd3,
        CFG_TANGENT_ONE_CENTER = 3'd4,
        CFG_TANGENT_TWO_CENTER = 3'd5,
        CFG_TANGENT_COS        = 3'd6,
        CFG_SECOND_PRESENT     = 3'd7
    } t_cfg_idx;

    // Number of vector components.
    localparam int NUM_COMP = 3;

endpackage

### hw/rtl/scpb_dir_if.sv
// Input channel: one direction word per handshake.
interface scpb_dir_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] dir_x;
    logic signed [COMPONENT_BITS-1:0] dir_y;
    logic signed [COMPONENT_BITS-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

### hw/rtl/scpb_res_if.sv
// Output channel: one bounds flag per handshake.
interface scpb_res_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, output allowed, input ready);
    modport sink   (input valid, input allowed, output ready);
endinterface

### hw/rtl/scpb_cross.sv
// Registered exact cross product of two packed fixed point vectors.
module scpb_cross
    import scpb_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                        i_clk,
    input  logic [NUM_COMP*W-1:0]       i_a,
    input  logic [NUM_COMP*W-1:0]       i_b,
    output logic [NUM_COMP*(2*W+1)-1:0] o_c
);
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [W-1:0]  w_a [NUM_COMP];
    logic signed [W-1:0]  w_b [NUM_COMP];
    logic signed [CW-1:0] w_c [NUM_COMP];
    logic [NUM_COMP*CW-1:0] n_c;
    logic [NUM_COMP*CW-1:0] r_c;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_a[k] = i_a[k*W +: W];
            w_b[k] = i_b[k*W +: W];
        end
        // x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
        for (int k = 0; k < NUM_COMP; k++) begin
            w_c[k] = CW'(PW'(w_a[(k+1)%NUM_COMP]) * PW'(w_b[(k+2)%NUM_COMP]))
                   - CW'(PW'(w_a[(k+2)%NUM_COMP]) * PW'(w_b[(k+1)%NUM_COMP]));
            n_c[k*CW +: CW] = w_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    assign o_c = r_c;
endmodule

### hw/rtl/spherical_cone_pair_bounds_test_core.sv
// Top level: pipelined test of a direction against a two-cone joint limit.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+------------------------------
//  i_dir     | in  | valid / ready   | dir_x, dir_y, dir_z (signed)
//  o_res     | out | valid / ready   | allowed
//  i_cfg_*   | in  | i_cfg_we        | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while o_res does not stall; four register stages, the
// capture, product, sum and triple-product stages, lie between i_dir and o_res; axis
// cross products are refreshed from the registers every cycle beside the pipeline.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on o_res holds the last stage; bubbles in front of it still close up.
module spherical_cone_pair_bounds_test_core
    import scpb_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scpb_dir_if.sink                         i_dir,
    scpb_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]          i_cfg_idx,
    input  logic [NUM_COMP*COMPONENT_BITS-1:0] i_cfg_data
);
    localparam int W     = COMPONENT_BITS;
    localparam int F     = W - 2;
    localparam int AW    = NUM_COMP * W;
    localparam int PW    = 2 * W;
    localparam int CW    = 2 * W + 1;
    localparam int H     = W + 1;
    localparam int HIW   = CW - H;
    localparam int LO_PW = W + H + 1;
    localparam int HI_PW = W + HIW;
    localparam int LO_SW = LO_PW + 2;
    localparam int HI_SW = HI_PW + 2;
    localparam int DW    = PW + 2;
    localparam int TW    = HI_SW + H + 1;

    localparam logic signed [W-1:0] COS_ONE = W'(1) << F;

    // Vector slots and cross product slots.
    localparam int NV   = 4;
    localparam int V_A  = 0;
    localparam int V_B  = 1;
    localparam int V_T1 = 2;
    localparam int V_T2 = 3;
    localparam int NX    = 5;
    localparam int X_AB  = 0;
    localparam int X_AT1 = 1;
    localparam int X_T1B = 2;
    localparam int X_T2A = 3;
    localparam int X_BT2 = 4;

    // Configuration registers.
    logic [AW-1:0]       r_cone_a_axis;
    logic signed [W-1:0] r_cone_a_cos;
    logic [AW-1:0]       r_cone_b_axis;
    logic signed [W-1:0] r_cone_b_cos;
    logic [AW-1:0]       r_tangent_one_center;
    logic [AW-1:0]       r_tangent_two_center;
    logic signed [W-1:0] r_tangent_cos;
    logic                r_second_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cone_a_axis        <= '0;
            r_cone_a_cos         <= COS_ONE;
            r_cone_b_axis        <= '0;
            r_cone_b_cos         <= COS_ONE;
            r_tangent_one_center <= '0;
            r_tangent_two_center <= '0;
            r_tangent_cos        <= COS_ONE;
            r_second_present     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CONE_A_AXIS:        r_cone_a_axis        <= i_cfg_data;
                CFG_CONE_A_COS:         r_cone_a_cos         <= i_cfg_data[W-1:0];
                CFG_CONE_B_AXIS:        r_cone_b_axis        <= i_cfg_data;
                CFG_CONE_B_COS:         r_cone_b_cos         <= i_cfg_data[W-1:0];
                CFG_TANGENT_ONE_CENTER: r_tangent_one_center <= i_cfg_data;
                CFG_TANGENT_TWO_CENTER: r_tangent_two_center <= i_cfg_data;
                CFG_TANGENT_COS:        r_tangent_cos        <= i_cfg_data[W-1:0];
                CFG_SECOND_PRESENT:     r_second_present     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Cross products of the fixed vectors, registered; they follow the registers in the next cycle.
    logic [NUM_COMP*CW-1:0] w_cross [NX];

    scpb_cross #(.W(W)) u_cross_ab (
        .i_clk(i_clk), .i_a(r_cone_a_axis), .i_b(r_cone_b_axis), .o_c(w_cross[X_AB])
    );
    scpb_cross #(.W(W)) u_cross_at1 (
        .i_clk(i_clk), .i_a(r_cone_a_axis), .i_b(r_tangent_one_center),
        .o_c(w_cross[X_AT1])
    );
    scpb_cross #(.W(W)) u_cross_t1b (
        .i_clk(i_clk), .i_a(r_tangent_one_center), .i_b(r_cone_b_axis),
        .o_c(w_cross[X_T1B])
    );
    scpb_cross #(.W(W)) u_cross_t2a (
        .i_clk(i_clk), .i_a(r_tangent_two_center), .i_b(r_cone_a_axis),
        .o_c(w_cross[X_T2A])
    );
    scpb_cross #(.W(W)) u_cross_bt2 (
        .i_clk(i_clk), .i_a(r_cone_b_axis), .i_b(r_tangent_two_center),
        .o_c(w_cross[X_BT2])
    );

    // Stage ready chain: a stage loads when it is empty or its word moves on.
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_rdy4 = !r_v4 || o_res.ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_dir.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_dir.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: capture the direction.
    logic signed [W-1:0] r_d1 [NUM_COMP];

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_d1[0] <= i_dir.dir_x;
            r_d1[1] <= i_dir.dir_y;
            r_d1[2] <= i_dir.dir_z;
        end
    end

    // Stage 2: all component products. Cross components split into a signed
    // high part and an unsigned low part to keep each multiplier narrow.
    logic signed [W-1:0]     w_vec   [NV][NUM_COMP];
    logic signed [CW-1:0]    w_cx    [NUM_COMP];
    logic signed [H:0]       w_cx_lo;
    logic signed [HIW-1:0]   w_cx_hi;
    logic signed [PW-1:0]    n_dp2   [NV][NUM_COMP];
    logic signed [LO_PW-1:0] n_lo2   [NX][NUM_COMP];
    logic signed [HI_PW-1:0] n_hi2   [NX][NUM_COMP];
    logic signed [PW-1:0]    r_dp2   [NV][NUM_COMP];
    logic signed [LO_PW-1:0] r_lo2   [NX][NUM_COMP];
    logic signed [HI_PW-1:0] r_hi2   [NX][NUM_COMP];

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_vec[V_A][k]  = r_cone_a_axis[k*W +: W];
            w_vec[V_B][k]  = r_cone_b_axis[k*W +: W];
            w_vec[V_T1][k] = r_tangent_one_center[k*W +: W];
            w_vec[V_T2][k] = r_tangent_two_center[k*W +: W];
        end
        for (int v = 0; v < NV; v++) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                n_dp2[v][k] = PW'(w_vec[v][k]) * PW'(r_d1[k]);
            end
        end
        w_cx_lo = '0;
        w_cx_hi = '0;
        for (int t = 0; t < NX; t++) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                w_cx[k]     = w_cross[t][k*CW +: CW];
                w_cx_lo     = {1'b0, w_cx[k][H-1:0]};
                w_cx_hi     = w_cx[k][CW-1:H];
                n_lo2[t][k] = LO_PW'(r_d1[k]) * LO_PW'(w_cx_lo);
                n_hi2[t][k] = HI_PW'(r_d1[k]) * HI_PW'(w_cx_hi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_dp2 <= n_dp2;
            r_lo2 <= n_lo2;
            r_hi2 <= n_hi2;
        end
    end

    // Stage 3: dot product sums, cone and tangent circle compares, partial sums.
    logic signed [DW-1:0]    w_dot [NV];
    logic signed [DW-1:0]    w_cos_a, w_cos_b, w_cos_t;
    logic                    n_in_a3, n_in_b3, n_over_t3;
    logic signed [LO_SW-1:0] n_los3 [NX];
    logic signed [HI_SW-1:0] n_his3 [NX];
    logic                    r_in_a3, r_in_b3, r_over_t3;
    logic signed [LO_SW-1:0] r_los3 [NX];
    logic signed [HI_SW-1:0] r_his3 [NX];

    always_comb begin
        for (int v = 0; v < NV; v++) begin
            w_dot[v] = DW'(r_dp2[v][0]) + DW'(r_dp2[v][1]) + DW'(r_dp2[v][2]);
        end
        w_cos_a   = DW'(r_cone_a_cos) <<< F;
        w_cos_b   = DW'(r_cone_b_cos) <<< F;
        w_cos_t   = DW'(r_tangent_cos) <<< F;
        n_in_a3   = w_dot[V_A] >= w_cos_a;
        n_in_b3   = w_dot[V_B] >= w_cos_b;
        n_over_t3 = (w_dot[V_T1] > w_cos_t) || (w_dot[V_T2] > w_cos_t);
        for (int t = 0; t < NX; t++) begin
            n_los3[t] = LO_SW'(r_lo2[t][0]) + LO_SW'(r_lo2[t][1]) + LO_SW'(r_lo2[t][2]);
            n_his3[t] = HI_SW'(r_hi2[t][0]) + HI_SW'(r_hi2[t][1]) + HI_SW'(r_hi2[t][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_in_a3   <= n_in_a3;
            r_in_b3   <= n_in_b3;
            r_over_t3 <= n_over_t3;
            r_los3    <= n_los3;
            r_his3    <= n_his3;
        end
    end

    // Stage 4: rebuild triple products, take signs and decide.
    logic signed [TW-1:0] w_trip [NX];
    logic                 w_pos  [NX];
    logic                 n_res4;
    logic                 r_res4;

    always_comb begin
        for (int t = 0; t < NX; t++) begin
            w_trip[t] = (TW'(r_his3[t]) <<< H) + TW'(r_los3[t]);
            w_pos[t]  = !w_trip[t][TW-1] && (w_trip[t] != '0);
        end
        if (r_in_a3) begin
            n_res4 = 1'b1;
        end else if (r_second_present && r_in_b3) begin
            n_res4 = 1'b1;
        end else if (!r_second_present || r_over_t3) begin
            n_res4 = 1'b0;
        end else if (w_trip[X_AB][TW-1]) begin
            n_res4 = w_pos[X_AT1] && w_pos[X_T1B];
        end else begin
            n_res4 = w_pos[X_T2A] && w_pos[X_BT2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_res4 <= n_res4;
        end
    end

    assign o_res.valid   = r_v4;
    assign o_res.allowed = r_res4;

`ifndef SYNTHESIS
    // A word inside cone A always comes out allowed.
    a_cone_a_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_in_a3 && w_rdy4) |=> (r_v4 && r_res4))
        else $error("cone A hit was not flagged allowed");

    // With a single cone, a miss of cone A is out of bounds.
    a_single_cone_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_in_a3 && !r_second_present && w_rdy4) |=> !r_res4)
        else $error("single cone miss flagged allowed");

    // An empty front stage never blocks the input.
    a_front_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_dir.ready)
        else $error("input stalled with empty front stage");
`endif
endmodule

### test/tb.sv
// Testbench for the cone pair bounds test core: directed and random directions vs a predictor.
`timescale 1ns / 100ps

module tb
    import scpb_pkg::*;
();

    localparam int COMPONENT_BITS = 16;
    localparam int AXIS_BITS      = NUM_COMP * COMPONENT_BITS;
    localparam int FRAC_BITS      = COMPONENT_BITS - 2;
    localparam int RANDOM_ITEMS   = 1400;

    typedef enum int {
        COMP_FULL,
        COMP_UNIT,
        COMP_EDGE
    } t_comp_mode;

    typedef enum int {
        LIMITS_NOISE,
        LIMITS_NARROW,
        LIMITS_EDGE
    } t_limits_kind;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_vec;

    typedef struct {
        logic [AXIS_BITS-1:0]      a_axis;
        logic [COMPONENT_BITS-1:0] a_cos;
        logic [AXIS_BITS-1:0]      b_axis;
        logic [COMPONENT_BITS-1:0] b_cos;
        logic [AXIS_BITS-1:0]      t1_center;
        logic [AXIS_BITS-1:0]      t2_center;
        logic [COMPONENT_BITS-1:0] t_cos;
        logic                      present;
    } t_cone_limits;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [AXIS_BITS-1:0] i_cfg_data;

    scpb_dir_if #(.COMPONENT_BITS(COMPONENT_BITS)) dir_ch ();
    scpb_res_if res_ch ();

    spherical_cone_pair_bounds_test_core #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      (dir_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_cone_limits active_limits;
    logic         bounds_expected[$];
    int           errors     = 0;
    int           burst_left = 0;
    int unsigned  rx_span    = 0;
    int unsigned  rx_period  = 1;
    int unsigned  rx_busy    = 0;
    int unsigned  rx_phase   = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_vec unpack_vec(input logic [AXIS_BITS-1:0] p);
        t_vec v;
        v.x = longint'($signed(p[COMPONENT_BITS-1:0]));
        v.y = longint'($signed(p[2*COMPONENT_BITS-1:COMPONENT_BITS]));
        v.z = longint'($signed(p[3*COMPONENT_BITS-1:2*COMPONENT_BITS]));
        return v;
    endfunction

    function automatic longint dot_vec(input t_vec a, input t_vec b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic t_vec cross_vec(input t_vec a, input t_vec b);
        t_vec r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    // Cosine raised to the fraction scale of a dot product.
    function automatic longint cos_scaled(input logic [COMPONENT_BITS-1:0] c);
        return longint'($signed(c)) * (longint'(1) << FRAC_BITS);
    endfunction

    function automatic logic predict_allowed(input logic [COMPONENT_BITS-1:0] dx,
                                             input logic [COMPONENT_BITS-1:0] dy,
                                             input logic [COMPONENT_BITS-1:0] dz);
        t_vec d;
        t_vec a;
        t_vec b;
        t_vec t1;
        t_vec t2;
        logic two;
        d     = unpack_vec({dz, dy, dx});
        a     = unpack_vec(active_limits.a_axis);
        b     = unpack_vec(active_limits.b_axis);
        t1    = unpack_vec(active_limits.t1_center);
        t2    = unpack_vec(active_limits.t2_center);
        two   = active_limits.present;
        if (dot_vec(a, d) >= cos_scaled(active_limits.a_cos))
            return 1'b1;
        if (two && dot_vec(b, d) >= cos_scaled(active_limits.b_cos))
            return 1'b1;
        if (!two)
            return 1'b0;
        if (dot_vec(t1, d) > cos_scaled(active_limits.t_cos))
            return 1'b0;
        if (dot_vec(t2, d) > cos_scaled(active_limits.t_cos))
            return 1'b0;
        // The side of the A-B great circle picks which tangent pair bounds the band.
        if (dot_vec(d, cross_vec(a, b)) < 0)
            return dot_vec(d, cross_vec(a, t1)) > 0 && dot_vec(d, cross_vec(t1, b)) > 0;
        return dot_vec(d, cross_vec(t2, a)) > 0 && dot_vec(d, cross_vec(b, t2)) > 0;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic logic [AXIS_BITS-1:0] pack_vec(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [AXIS_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Hold the direction channel idle and wait until every word has come back.
    task automatic drain_results();
        @(negedge i_clk);
        dir_ch.valid <= 1'b0;
        while (bounds_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Write every register; narrow ones carry random upper bits that must be dropped.
    task automatic apply_limits(input t_cone_limits lim);
        logic [AXIS_BITS-1:0] noise;
        drain_results();
        noise = AXIS_BITS'({$urandom, $urandom});
        write_reg(CFG_CONE_A_AXIS, lim.a_axis);
        write_reg(CFG_CONE_A_COS, {noise[AXIS_BITS-1:COMPONENT_BITS], lim.a_cos});
        write_reg(CFG_CONE_B_AXIS, lim.b_axis);
        noise = AXIS_BITS'({$urandom, $urandom});
        write_reg(CFG_CONE_B_COS, {noise[AXIS_BITS-1:COMPONENT_BITS], lim.b_cos});
        write_reg(CFG_TANGENT_ONE_CENTER, lim.t1_center);
        write_reg(CFG_TANGENT_TWO_CENTER, lim.t2_center);
        noise = AXIS_BITS'({$urandom, $urandom});
        write_reg(CFG_TANGENT_COS, {noise[AXIS_BITS-1:COMPONENT_BITS], lim.t_cos});
        noise = AXIS_BITS'({$urandom, $urandom});
        write_reg(CFG_SECOND_PRESENT, {noise[AXIS_BITS-1:1], lim.present});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_limits = lim;
    endtask

    // Send one direction word; the sender runs in bursts separated by random gaps.
    task automatic send_dir(input logic [COMPONENT_BITS-1:0] x,
                            input logic [COMPONENT_BITS-1:0] y,
                            input logic [COMPONENT_BITS-1:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                dir_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= x;
        dir_ch.dir_y <= y;
        dir_ch.dir_z <= z;
        do @(posedge i_clk); while (dir_ch.ready !== 1'b1);
        bounds_expected.push_back(predict_allowed(x, y, z));
    endtask

    // Receiver: stall the first rx_busy phases of every rx_period, new pattern per span.
    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_span   = $urandom_range(16, 96);
            rx_period = $urandom_range(2, 8);
            rx_busy   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, rx_period - 1);
            rx_phase  = 0;
        end
        res_ch.ready <= (rx_phase >= rx_busy);
        rx_phase = (rx_phase + 1) % rx_period;
        rx_span--;
    end

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (bounds_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual allowed=%0b",
                         $time, res_ch.allowed);
                errors++;
            end else begin
                want = bounds_expected.pop_front();
                if (res_ch.allowed !== want) begin
                    $display("%0t: allowed mismatch, expected %0b, actual %0b",
                             $time, want, res_ch.allowed);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [COMPONENT_BITS-1:0] random_comp(input t_comp_mode mode);
        case (mode)
            COMP_UNIT: return 16'($urandom_range(0, 32768) - 16384);
            COMP_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'h4000;
                    default: return 16'hC000;
                endcase
            end
            default:   return 16'($urandom);
        endcase
    endfunction

    function automatic logic [AXIS_BITS-1:0] random_axis(input t_comp_mode mode);
        return {random_comp(mode), random_comp(mode), random_comp(mode)};
    endfunction

    function automatic logic [COMPONENT_BITS-1:0] random_cos(input t_limits_kind kind);
        case (kind)
            LIMITS_NARROW: return 16'($urandom_range(9000, 16384));
            LIMITS_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hC000;
                    3:       return 16'h4000;
                    default: return 16'h0000;
                endcase
            end
            default:       return 16'($urandom);
        endcase
    endfunction

    function automatic t_cone_limits random_limits(input t_limits_kind kind);
        t_cone_limits lim;
        t_comp_mode   mode;
        mode = (kind == LIMITS_NARROW) ? COMP_UNIT :
               (kind == LIMITS_EDGE)   ? COMP_EDGE : COMP_FULL;
        lim.a_axis    = random_axis(mode);
        lim.a_cos     = random_cos(kind);
        lim.b_axis    = random_axis(mode);
        lim.b_cos     = random_cos(kind);
        lim.t1_center = random_axis(mode);
        lim.t2_center = random_axis(mode);
        lim.t_cos     = random_cos(kind);
        lim.present   = ($urandom_range(0, 3) != 0);
        return lim;
    endfunction

    // Reset state: zero axes with unit cosine reject every direction.
    task automatic test_reset_limits();
        send_dir(16'sd16384, 16'sd0, 16'sd0);
        send_dir(16'sd0, 16'sd0, 16'sd0);
        send_dir(16'h8000, 16'h8000, 16'h8000);
    endtask

    // Single cone: cone B and the tangent circles must be ignored.
    task automatic test_single_cone();
        t_cone_limits lim;
        lim.a_axis    = pack_vec(16384, 0, 0);
        lim.a_cos     = 16'sd11585;
        lim.b_axis    = pack_vec(0, 16384, 0);
        lim.b_cos     = 16'h8000;
        lim.t1_center = pack_vec(0, 16384, 0);
        lim.t2_center = pack_vec(0, 0, 16384);
        lim.t_cos     = 16'h8000;
        lim.present   = 1'b0;
        apply_limits(lim);
        send_dir(16'sd16384, 16'sd0, 16'sd0);
        send_dir(16'sd11585, 16'sd11585, 16'sd0);   // dot equals cosine exactly
        send_dir(16'sd11584, 16'sd11585, 16'sd0);
        send_dir(16'sd0, 16'sd16384, 16'sd0);
        send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_dir(16'h8000, 16'h8000, 16'h8000);
        // cosine far below -1 with an extreme direction on the boundary
        lim.a_cos = 16'h8000;
        apply_limits(lim);
        send_dir(16'h8000, 16'sd0, 16'sd0);
        send_dir(16'h8000, 16'h8000, 16'sd0);
        // cosine above +1, reached only by an over-long direction
        lim.a_cos = 16'h7FFF;
        apply_limits(lim);
        send_dir(16'h7FFF, 16'sd0, 16'sd0);
        send_dir(16'h7FFE, 16'sd0, 16'sd0);
    endtask

    // Two cones on x and y, tangent circles above and below the joining band.
    task automatic test_cone_pair();
        t_cone_limits lim;
        lim.a_axis    = pack_vec(16384, 0, 0);
        lim.a_cos     = 16'sd14189;
        lim.b_axis    = pack_vec(0, 16384, 0);
        lim.b_cos     = 16'sd14189;
        lim.t1_center = pack_vec(8192, 8192, -11585);
        lim.t2_center = pack_vec(8192, 8192, 11585);
        lim.t_cos     = 16'sd14189;
        lim.present   = 1'b1;
        apply_limits(lim);
        send_dir(16'sd16384, 16'sd0, 16'sd0);
        send_dir(16'sd0, 16'sd16384, 16'sd0);
        send_dir(16'sd8192, 16'sd8192, -16'sd11585);
        send_dir(16'sd8192, 16'sd8192, 16'sd11585);
        send_dir(16'sd11585, 16'sd11585, 16'sd0);
        send_dir(16'sd11585, 16'sd11585, -16'sd4000);
        send_dir(16'sd11585, 16'sd11585, 16'sd4000);
        send_dir(-16'sd16384, 16'sd0, 16'sd0);
        send_dir(16'sd0, 16'sd0, 16'sd16384);
        lim.present = 1'b0;
        apply_limits(lim);
        send_dir(16'sd0, 16'sd16384, 16'sd0);
    endtask

    // Random limit settings, each followed by a run of random directions.
    task automatic test_random_limits();
        int           sent;
        int           run;
        t_limits_kind kind;
        t_comp_mode   mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0, 1:    kind = LIMITS_NOISE;
                5:       kind = LIMITS_EDGE;
                default: kind = LIMITS_NARROW;
            endcase
            apply_limits(random_limits(kind));
            run = $urandom_range(60, 160);
            if (run > RANDOM_ITEMS - sent)
                run = RANDOM_ITEMS - sent;
            repeat (run) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mode = COMP_FULL;
                    9:       mode = COMP_EDGE;
                    default: mode = COMP_UNIT;
                endcase
                send_dir(random_comp(mode), random_comp(mode), random_comp(mode));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_CONE_A_AXIS;
        i_cfg_data    = '0;
        dir_ch.valid  = 1'b0;
        dir_ch.dir_x  = '0;
        dir_ch.dir_y  = '0;
        dir_ch.dir_z  = '0;
        res_ch.ready  = 1'b0;
        active_limits.a_axis    = '0;
        active_limits.a_cos     = 16'sd16384;
        active_limits.b_axis    = '0;
        active_limits.b_cos     = 16'sd16384;
        active_limits.t1_center = '0;
        active_limits.t2_center = '0;
        active_limits.t_cos     = 16'sd16384;
        active_limits.present   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limits();
        test_single_cone();
        test_cone_pair();
        test_random_limits();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
